// ===== rtl/cpu8_alu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8_alu_pkg
// Types and constants shared by the register and ALU execute stage: request
// and response payloads, the architectural register set and operation codes.
// ----------------------------------------------------------------------------
package cpu8_alu_pkg;

   localparam int OP_WIDTH = 6;

   // operation codes
   localparam logic [OP_WIDTH-1:0] OP_LDA = 6'd0;
   localparam logic [OP_WIDTH-1:0] OP_LDX = 6'd1;
   localparam logic [OP_WIDTH-1:0] OP_LDY = 6'd2;
   localparam logic [OP_WIDTH-1:0] OP_STA = 6'd3;
   localparam logic [OP_WIDTH-1:0] OP_STX = 6'd4;
   localparam logic [OP_WIDTH-1:0] OP_STY = 6'd5;
   localparam logic [OP_WIDTH-1:0] OP_TAX = 6'd6;
   localparam logic [OP_WIDTH-1:0] OP_TAY = 6'd7;
   localparam logic [OP_WIDTH-1:0] OP_TXA = 6'd8;
   localparam logic [OP_WIDTH-1:0] OP_TYA = 6'd9;
   localparam logic [OP_WIDTH-1:0] OP_TSX = 6'd10;
   localparam logic [OP_WIDTH-1:0] OP_TXS = 6'd11;
   localparam logic [OP_WIDTH-1:0] OP_AND = 6'd12;
   localparam logic [OP_WIDTH-1:0] OP_EOR = 6'd13;
   localparam logic [OP_WIDTH-1:0] OP_ORA = 6'd14;
   localparam logic [OP_WIDTH-1:0] OP_BIT = 6'd15;
   localparam logic [OP_WIDTH-1:0] OP_ADC = 6'd16;
   localparam logic [OP_WIDTH-1:0] OP_SBC = 6'd17;
   localparam logic [OP_WIDTH-1:0] OP_CMP = 6'd18;
   localparam logic [OP_WIDTH-1:0] OP_CPX = 6'd19;
   localparam logic [OP_WIDTH-1:0] OP_CPY = 6'd20;
   localparam logic [OP_WIDTH-1:0] OP_INC = 6'd21;
   localparam logic [OP_WIDTH-1:0] OP_INX = 6'd22;
   localparam logic [OP_WIDTH-1:0] OP_INY = 6'd23;
   localparam logic [OP_WIDTH-1:0] OP_DEC = 6'd24;
   localparam logic [OP_WIDTH-1:0] OP_DEX = 6'd25;
   localparam logic [OP_WIDTH-1:0] OP_DEY = 6'd26;
   localparam logic [OP_WIDTH-1:0] OP_ASL = 6'd27;
   localparam logic [OP_WIDTH-1:0] OP_LSR = 6'd28;
   localparam logic [OP_WIDTH-1:0] OP_ROL = 6'd29;
   localparam logic [OP_WIDTH-1:0] OP_ROR = 6'd30;
   localparam logic [OP_WIDTH-1:0] OP_CLC = 6'd31;
   localparam logic [OP_WIDTH-1:0] OP_CLD = 6'd32;
   localparam logic [OP_WIDTH-1:0] OP_CLI = 6'd33;
   localparam logic [OP_WIDTH-1:0] OP_CLV = 6'd34;
   localparam logic [OP_WIDTH-1:0] OP_SEC = 6'd35;
   localparam logic [OP_WIDTH-1:0] OP_SED = 6'd36;
   localparam logic [OP_WIDTH-1:0] OP_SEI = 6'd37;
   localparam logic [OP_WIDTH-1:0] OP_NOP = 6'd38;

   // status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] SP_RESET = 8'hFF;

   typedef struct packed {
      logic [OP_WIDTH-1:0] req_type;
      logic [7:0]          operand_byte;
      logic                use_accumulator;
   } req_type_type;

   typedef struct packed {
      logic       mem_write;
      logic [7:0] write_data;
      logic [7:0] acc_value;
      logic [7:0] x_value;
      logic [7:0] y_value;
      logic [7:0] sp_value;
      logic [7:0] flags_value;
   } rsp_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] stack_pointer;
      logic [7:0] status_flags;
   } regs_type;

endpackage

// ===== rtl/cpu8_alu_core.sv =====
// ----------------------------------------------------------------------------
// cpu8_alu_core
// Combinational execute logic: takes one request and the current register
// set, returns the next register set and the memory write-back.
// ----------------------------------------------------------------------------
module cpu8_alu_core (
   input  cpu8_alu_pkg::req_type_type req,
   input  cpu8_alu_pkg::regs_type     regs,
   output cpu8_alu_pkg::regs_type     regs_next,
   output logic                       mem_write,
   output logic [7:0]                 write_data
);
   import cpu8_alu_pkg::*;

   logic [7:0] m;
   logic [7:0] addend;
   logic [8:0] sum;
   logic [7:0] cmp_reg;
   logic [8:0] diff;
   logic [7:0] shift_src;
   logic [7:0] shift_res;
   logic [7:0] nz_value;
   logic       nz_update;
   logic       cin;
   logic [7:0] fl;

   assign m      = req.operand_byte;
   assign cin    = regs.status_flags[FLAG_C];
   assign addend = (req.req_type == OP_SBC) ? ~m : m;
   assign sum    = {1'b0, regs.acc} + {1'b0, addend} + {8'd0, cin};

   always_comb begin
      case (req.req_type)
         OP_CPX:  cmp_reg = regs.index_x;
         OP_CPY:  cmp_reg = regs.index_y;
         default: cmp_reg = regs.acc;
      endcase
   end

   assign diff      = {1'b0, cmp_reg} - {1'b0, m};
   assign shift_src = req.use_accumulator ? regs.acc : m;

   always_comb begin
      case (req.req_type)
         OP_ASL:  shift_res = {shift_src[6:0], 1'b0};
         OP_ROL:  shift_res = {shift_src[6:0], cin};
         OP_LSR:  shift_res = {1'b0, shift_src[7:1]};
         default: shift_res = {cin, shift_src[7:1]};
      endcase
   end

   always_comb begin
      regs_next  = regs;
      mem_write  = 1'b0;
      write_data = 8'd0;
      nz_value   = 8'd0;
      nz_update  = 1'b0;
      fl         = regs.status_flags;
      case (req.req_type)
         OP_LDA: begin
            regs_next.acc = m;
            nz_value = m; nz_update = 1'b1;
         end
         OP_LDX: begin
            regs_next.index_x = m;
            nz_value = m; nz_update = 1'b1;
         end
         OP_LDY: begin
            regs_next.index_y = m;
            nz_value = m; nz_update = 1'b1;
         end
         OP_STA: begin
            mem_write = 1'b1; write_data = regs.acc;
         end
         OP_STX: begin
            mem_write = 1'b1; write_data = regs.index_x;
         end
         OP_STY: begin
            mem_write = 1'b1; write_data = regs.index_y;
         end
         OP_TAX: begin
            regs_next.index_x = regs.acc;
            nz_value = regs.acc; nz_update = 1'b1;
         end
         OP_TAY: begin
            regs_next.index_y = regs.acc;
            nz_value = regs.acc; nz_update = 1'b1;
         end
         OP_TXA: begin
            regs_next.acc = regs.index_x;
            nz_value = regs.index_x; nz_update = 1'b1;
         end
         OP_TYA: begin
            regs_next.acc = regs.index_y;
            nz_value = regs.index_y; nz_update = 1'b1;
         end
         OP_TSX: begin
            regs_next.index_x = regs.stack_pointer;
            nz_value = regs.stack_pointer; nz_update = 1'b1;
         end
         OP_TXS: begin
            regs_next.stack_pointer = regs.index_x;
         end
         OP_AND: begin
            regs_next.acc = regs.acc & m;
            nz_value = regs.acc & m; nz_update = 1'b1;
         end
         OP_EOR: begin
            regs_next.acc = regs.acc ^ m;
            nz_value = regs.acc ^ m; nz_update = 1'b1;
         end
         OP_ORA: begin
            regs_next.acc = regs.acc | m;
            nz_value = regs.acc | m; nz_update = 1'b1;
         end
         OP_BIT: begin
            fl[FLAG_Z] = ((regs.acc & m) == 8'd0);
            fl[FLAG_V] = m[6];
            fl[FLAG_N] = m[7];
         end
         OP_ADC, OP_SBC: begin
            regs_next.acc = sum[7:0];
            fl[FLAG_C] = sum[8];
            fl[FLAG_V] = ~(regs.acc[7] ^ addend[7]) & (regs.acc[7] ^ sum[7]);
            nz_value = sum[7:0]; nz_update = 1'b1;
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            fl[FLAG_C] = ~diff[8];
            fl[FLAG_Z] = (cmp_reg == m);
            fl[FLAG_N] = diff[7];
         end
         OP_INC: begin
            mem_write = 1'b1; write_data = m + 8'd1;
            nz_value = m + 8'd1; nz_update = 1'b1;
         end
         OP_INX: begin
            regs_next.index_x = regs.index_x + 8'd1;
            nz_value = regs.index_x + 8'd1; nz_update = 1'b1;
         end
         OP_INY: begin
            regs_next.index_y = regs.index_y + 8'd1;
            nz_value = regs.index_y + 8'd1; nz_update = 1'b1;
         end
         OP_DEC: begin
            mem_write = 1'b1; write_data = m - 8'd1;
            nz_value = m - 8'd1; nz_update = 1'b1;
         end
         OP_DEX: begin
            regs_next.index_x = regs.index_x - 8'd1;
            nz_value = regs.index_x - 8'd1; nz_update = 1'b1;
         end
         OP_DEY: begin
            regs_next.index_y = regs.index_y - 8'd1;
            nz_value = regs.index_y - 8'd1; nz_update = 1'b1;
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            if (req.req_type == OP_ASL || req.req_type == OP_ROL) begin
               fl[FLAG_C] = shift_src[7];
            end else begin
               fl[FLAG_C] = shift_src[0];
            end
            nz_value = shift_res; nz_update = 1'b1;
            if (req.use_accumulator) begin
               regs_next.acc = shift_res;
            end else begin
               mem_write = 1'b1; write_data = shift_res;
            end
         end
         OP_CLC:  fl[FLAG_C] = 1'b0;
         OP_CLD:  fl[FLAG_D] = 1'b0;
         OP_CLI:  fl[FLAG_I] = 1'b0;
         OP_CLV:  fl[FLAG_V] = 1'b0;
         OP_SEC:  fl[FLAG_C] = 1'b1;
         OP_SED:  fl[FLAG_D] = 1'b1;
         OP_SEI:  fl[FLAG_I] = 1'b1;
         OP_NOP:  ;
         default: ;
      endcase
      if (nz_update) begin
         fl[FLAG_Z] = (nz_value == 8'd0);
         fl[FLAG_N] = nz_value[7];
      end
      regs_next.status_flags = fl;
   end

endmodule

// ===== rtl/cpu8_register_alu_execute.sv =====
// ----------------------------------------------------------------------------
// cpu8_register_alu_execute
// Execute stage of an 8-bit processor: holds A, X, Y, SP and status, runs
// one operation per request and returns the full register set plus any
// memory write-back byte.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data (op, operand, acc sel)
//   rsp      out        rsp_valid/rsp_stall   rsp_data (write-back, registers)
//
// one request per cycle sustained while rsp_stall is low; from accept to
// response: input register, then the ALU into the response register and the registers
// reset clears A, X, Y and status, sets SP to 0xFF and empties both stages
// a stalled response holds both stages; req_stall rises only when the input
// register is full and the response cannot move
// ----------------------------------------------------------------------------
module cpu8_register_alu_execute (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cpu8_alu_pkg::req_type_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cpu8_alu_pkg::rsp_type      rsp_data
);
   import cpu8_alu_pkg::*;

   logic         stage_valid_ff;
   req_type_type stage_req_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;
   regs_type     regs_ff;

   regs_type     regs_in;
   rsp_type      rsp_data_in;
   logic         mem_write;
   logic [7:0]   write_data;
   logic         out_free;
   logic         stage_move;
   logic         req_take;

   cpu8_alu_core u_core (
      .req        (stage_req_ff),
      .regs       (regs_ff),
      .regs_next  (regs_in),
      .mem_write  (mem_write),
      .write_data (write_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_move = stage_valid_ff && out_free;
   assign req_stall  = stage_valid_ff && !out_free;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      rsp_data_in.mem_write   = mem_write;
      rsp_data_in.write_data  = write_data;
      rsp_data_in.acc_value   = regs_in.acc;
      rsp_data_in.x_value     = regs_in.index_x;
      rsp_data_in.y_value     = regs_in.index_y;
      rsp_data_in.sp_value    = regs_in.stack_pointer;
      rsp_data_in.flags_value = regs_in.status_flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff        <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         regs_ff.acc           <= 8'd0;
         regs_ff.index_x       <= 8'd0;
         regs_ff.index_y       <= 8'd0;
         regs_ff.stack_pointer <= SP_RESET;
         regs_ff.status_flags  <= 8'd0;
      end else begin
         if (req_take) begin
            stage_valid_ff <= 1'b1;
         end else if (stage_move) begin
            stage_valid_ff <= 1'b0;
         end
         if (stage_move) begin
            rsp_valid_ff <= 1'b1;
            regs_ff      <= regs_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_req_ff <= req_data;
      end
      if (stage_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
